@@ design/periodic_row_gap_histogram_core_assert.svh @@
// Assertion macros shared by the histogram core modules.
`ifndef PERIODIC_ROW_GAP_HISTOGRAM_CORE_ASSERT_SVH
`define PERIODIC_ROW_GAP_HISTOGRAM_CORE_ASSERT_SVH
`ifndef SYNTH
`define PRGH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("prgh: assertion failed");
`define PRGH_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("prgh: assertion failed");
`else
`define PRGH_ASSERT(label, clk, rst, prop)
`define PRGH_ASSERT_NORST(label, clk, prop)
`endif
`endif

@@ design/prgh_pkg.sv @@
`timescale 1ns / 1ps

package prgh_pkg;

   // Lattice side is a power of two so that column wrap is a mask.
   localparam int SIDE_LOG2   = 4;
   localparam int SIDE        = 1 << SIDE_LOG2;
   localparam int NUM_BINS    = SIDE / 2;
   localparam int COL_W       = SIDE_LOG2;
   localparam int BIN_W       = SIDE_LOG2 - 1;
   localparam int CMD_W       = 3;
   localparam int VALUE_W     = 8;
   localparam int COUNT_W     = 32;
   localparam int SUM_W       = ((COL_W > VALUE_W) ? COL_W : VALUE_W) + 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] SITES_NONE = 2'd0;
   localparam logic [1:0] SITES_ONE  = 2'd1;
   localparam logic [1:0] SITES_FULL = 2'd3;

   typedef enum logic [CMD_W-1:0] {
      CMD_START = 3'd0,
      CMD_STEP  = 3'd1,
      CMD_END   = 3'd2,
      CMD_READ  = 3'd3,
      CMD_CLEAR = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      OP_BUMP  = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [BIN_W-1:0]  bin;
      logic              out_of_range;
   } queue_entry_type;

   // Folds a gap of 1 .. SIDE-1 to min(g, SIDE-g) and returns its bin index.
   function automatic logic [BIN_W-1:0] fold_bin(input logic [COL_W-1:0] gap);
      logic [COL_W:0] gap_x;
      logic [COL_W:0] rest;
      logic [COL_W:0] folded;
      logic [COL_W:0] folded_m1;
      gap_x     = {1'b0, gap};
      rest      = (COL_W + 1)'(SIDE) - gap_x;
      folded    = (rest < gap_x) ? rest : gap_x;
      folded_m1 = folded - 1'b1;
      return folded_m1[BIN_W-1:0];
   endfunction

endpackage

@@ design/prgh_front.sv @@
`timescale 1ns / 1ps

module prgh_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [prgh_pkg::CMD_W-1:0]       req_command,
   input  logic [prgh_pkg::VALUE_W-1:0]     req_value,
   output logic                             push_valid,
   output prgh_pkg::queue_entry_type        push_entry,
   input  logic                             push_ready
);

   logic [prgh_pkg::COL_W-1:0] col_ff, col_in;
   logic [prgh_pkg::COL_W-1:0] first_ff, first_in;
   logic [1:0]                 sites_ff, sites_in;

   logic                       accept;
   logic [prgh_pkg::SUM_W-1:0] value_x;
   logic [prgh_pkg::SUM_W-1:0] sum;
   logic                       crosses;
   logic                       close_ok;
   logic [prgh_pkg::COL_W-1:0] close_gap;

   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign value_x   = prgh_pkg::SUM_W'(req_value);
   assign sum       = prgh_pkg::SUM_W'(col_ff) + value_x;
   assign crosses   = sum >= prgh_pkg::SUM_W'(prgh_pkg::SIDE);
   assign close_ok  = (sites_ff == prgh_pkg::SITES_FULL) && (col_ff > first_ff);
   assign close_gap = col_ff - first_ff;

   always_comb begin
      col_in                  = col_ff;
      first_in                = first_ff;
      sites_in                = sites_ff;
      push_valid              = 1'b0;
      push_entry.op           = prgh_pkg::OP_BUMP;
      push_entry.bin          = value_x[prgh_pkg::BIN_W-1:0];
      push_entry.out_of_range = 1'b0;
      if (accept) begin
         unique case (prgh_pkg::cmd_type'(req_command))
            prgh_pkg::CMD_START: begin
               col_in   = value_x[prgh_pkg::COL_W-1:0];
               first_in = value_x[prgh_pkg::COL_W-1:0];
               sites_in = prgh_pkg::SITES_ONE;
            end
            prgh_pkg::CMD_STEP: begin
               if (sites_ff != prgh_pkg::SITES_NONE && req_value != '0) begin
                  col_in = sum[prgh_pkg::COL_W-1:0];
                  if (crosses) begin
                     push_valid     = close_ok;
                     push_entry.bin = prgh_pkg::fold_bin(close_gap);
                     first_in       = sum[prgh_pkg::COL_W-1:0];
                     sites_in       = prgh_pkg::SITES_ONE;
                  end else begin
                     // No wrap, so the step is below SIDE and fits a column.
                     push_valid     = 1'b1;
                     push_entry.bin = prgh_pkg::fold_bin(value_x[prgh_pkg::COL_W-1:0]);
                     if (sites_ff != prgh_pkg::SITES_FULL) begin
                        sites_in = sites_ff + 1'b1;
                     end
                  end
               end
            end
            prgh_pkg::CMD_END: begin
               push_valid     = (sites_ff != prgh_pkg::SITES_NONE) && close_ok;
               push_entry.bin = prgh_pkg::fold_bin(close_gap);
               sites_in       = prgh_pkg::SITES_NONE;
            end
            prgh_pkg::CMD_READ: begin
               push_valid              = 1'b1;
               push_entry.op           = prgh_pkg::OP_READ;
               push_entry.out_of_range =
                  value_x >= prgh_pkg::SUM_W'(prgh_pkg::NUM_BINS);
            end
            prgh_pkg::CMD_CLEAR: begin
               push_valid    = 1'b1;
               push_entry.op = prgh_pkg::OP_CLEAR;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         first_ff <= '0;
         sites_ff <= prgh_pkg::SITES_NONE;
      end else begin
         col_ff   <= col_in;
         first_ff <= first_in;
         sites_ff <= sites_in;
      end
   end

`include "periodic_row_gap_histogram_core_assert.svh"

   `PRGH_ASSERT(a_start_opens_row, clock, reset, (accept && req_command == prgh_pkg::CMD_START) |=> (sites_ff == prgh_pkg::SITES_ONE))

endmodule

@@ design/prgh_queue.sv @@
`timescale 1ns / 1ps

module prgh_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  prgh_pkg::queue_entry_type push_entry,
   output logic                      push_ready,
   output logic                      head_valid,
   output prgh_pkg::queue_entry_type head_entry,
   input  logic                      pop
);

   prgh_pkg::queue_entry_type         entries_ff [prgh_pkg::QUEUE_DEPTH];
   logic [prgh_pkg::QPTR_W-1:0]       head_ff, head_in;
   logic [prgh_pkg::QPTR_W-1:0]       tail_ff, tail_in;
   logic [prgh_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              push;
   logic                              take;

   localparam logic [prgh_pkg::QPTR_W-1:0] LAST_PTR =
      prgh_pkg::QPTR_W'(prgh_pkg::QUEUE_DEPTH - 1);

   assign push_ready = count_ff != prgh_pkg::QCNT_W'(prgh_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = entries_ff[head_ff];
   assign push       = push_valid && push_ready;
   assign take       = pop && head_valid;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
      end
      if (take) begin
         head_in = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[tail_ff] <= push_entry;
      end
   end

`include "periodic_row_gap_histogram_core_assert.svh"

   `PRGH_ASSERT(a_count_bound, clock, reset, count_ff <= prgh_pkg::QCNT_W'(prgh_pkg::QUEUE_DEPTH))
   `PRGH_ASSERT(a_count_grows, clock, reset, (push && !take) |=> (count_ff == $past(count_ff) + 1'b1))

endmodule

@@ design/prgh_back.sv @@
`timescale 1ns / 1ps

module prgh_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  prgh_pkg::queue_entry_type        head_entry,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [prgh_pkg::COUNT_W-1:0]     rsp_bin_count
);

   logic [prgh_pkg::COUNT_W-1:0] bins_ff [prgh_pkg::NUM_BINS];
   logic [prgh_pkg::COUNT_W-1:0] bins_in [prgh_pkg::NUM_BINS];
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [prgh_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                         is_read;
   logic                         do_bump;
   logic                         do_clear;
   logic                         do_read;

   assign is_read  = head_entry.op == prgh_pkg::OP_READ;
   // A read waits only while the output register still holds an untaken result.
   assign pop      = head_valid && (!is_read || !rsp_valid_ff || rsp_ready);
   assign do_bump  = pop && (head_entry.op == prgh_pkg::OP_BUMP);
   assign do_clear = pop && (head_entry.op == prgh_pkg::OP_CLEAR);
   assign do_read  = pop && is_read;

   always_comb begin
      for (int i = 0; i < prgh_pkg::NUM_BINS; i++) begin
         bins_in[i] = bins_ff[i];
         if (do_clear) begin
            bins_in[i] = '0;
         end else if (do_bump && head_entry.bin == prgh_pkg::BIN_W'(i)
                      && bins_ff[i] != '1) begin
            bins_in[i] = bins_ff[i] + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      if (do_read) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = head_entry.out_of_range ? '0 : bins_ff[head_entry.bin];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < prgh_pkg::NUM_BINS; i++) begin
            bins_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         bins_ff      <= bins_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_count = rsp_count_ff;

`include "periodic_row_gap_histogram_core_assert.svh"

   `PRGH_ASSERT(a_read_gives_result, clock, reset, do_read |=> rsp_valid_ff)
   `PRGH_ASSERT(a_clear_zeroes, clock, reset, do_clear |=> (bins_ff[0] == '0))

endmodule

@@ design/periodic_row_gap_histogram_core.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Ports                                   Carries
// req       in         req_valid req_ready req_command         one command transaction
//                      req_value
// rsp       out        rsp_valid rsp_ready rsp_bin_count       bin count of a read
//
// One transaction is taken per cycle while req_ready is high; the front
// classifies it in the cycle it is accepted and the back applies it once it
// leaves the queue. A read result reaches rsp through the queue entry and the
// output register.
// Reset is synchronous; it clears the open row state, the queue and all bins.
// A result held on rsp stalls only the read behind it; the two-entry queue then
// fills and req_ready falls.

module periodic_row_gap_histogram_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [prgh_pkg::CMD_W-1:0]       req_command,
   input  logic [prgh_pkg::VALUE_W-1:0]     req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [prgh_pkg::COUNT_W-1:0]     rsp_bin_count
);

   // Front to queue: at most one histogram operation per transaction.
   logic                      push_valid;
   logic                      push_ready;
   prgh_pkg::queue_entry_type push_entry;

   // Queue to back.
   logic                      head_valid;
   prgh_pkg::queue_entry_type head_entry;
   logic                      pop;

   // The front keeps the open row (current column, first column, site count)
   // and turns steps, row closes, reads and clears into queue entries. Every
   // row update is registered as its step is accepted, so consecutive steps need no forwarding.
   prgh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_value   (req_value),
      .push_valid  (push_valid),
      .push_entry  (push_entry),
      .push_ready  (push_ready)
   );

   // The queue keeps entries in order, so a read always sees every bump and
   // clear from the transactions before it.
   prgh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   // The back holds the saturating bins and the registered read result.
   prgh_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_bin_count (rsp_bin_count)
   );

endmodule
